FILE: src/tlvfp_pkg.sv
// Package for the TLV frame parser: field widths, default header sizes
// and the result record type. No dependencies.
package tlvfp_pkg;

    localparam int BYTE_W            = 8;
    localparam int TYPE_W            = 16;
    localparam int TYPE_BYTES_DEF    = 2;
    localparam int LENGTH_BYTES_DEF  = 4;
    localparam int OUT_DATA_W        = BYTE_W + TYPE_W;

    typedef struct packed {
        logic              empty_res;
        logic              last;
        logic [TYPE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_byte;
    } result_t;

endpackage

FILE: src/tlv_frame_parser.sv
// TLV frame parser top level: header parse state, payload counter and a
// two-entry result buffer (output register plus skid register).
// Depends on tlvfp_pkg.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata[7:0]       in_byte
//  m_axis    out        tvalid tready tdata[23:0]      payload_byte, frame_type
//                       tlast tuser[0]                 last, empty_res
//
// One input item is taken per clock while s_axis_tready is high; each result is registered.
// The rate is set by the parse state update, a shift and a 32-bit decrement.
// rst_n clears the header position, type, length, payload counter and both result valid flags.
// The skid register lets an item enter while a result waits, so s_axis_tready
// comes from a register and drops only when both result slots are full.
module tlv_frame_parser
    import tlvfp_pkg::*;
#(
    parameter int TYPE_BYTES   = TYPE_BYTES_DEF,
    parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_type
    output logic                  m_axis_tlast,   // last
    output logic [0:0]            m_axis_tuser    // [0] empty_res
);

    localparam int HDR_BYTES = TYPE_BYTES + LENGTH_BYTES;
    localparam int POS_W     = $clog2(HDR_BYTES);
    localparam int LEN_W     = BYTE_W * LENGTH_BYTES;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LEN0 = POS_W'(TYPE_BYTES);

    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [TYPE_W-1:0] type_reg,      type_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;

    logic              out_valid_reg;
    logic              skid_valid_reg;
    result_t           out_reg;
    result_t           skid_reg;

    logic              accept;
    logic              in_payload;
    logic [LEN_W-1:0]  len_shift;
    logic              new_res;
    result_t           new_item;
    logic              drain;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign in_payload = (remaining_reg != '0);
    assign len_shift  = (len_reg << BYTE_W) | LEN_W'(s_axis_tdata);
    assign drain      = out_valid_reg && m_axis_tready;

    always_comb
    begin
        pos_next       = pos_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        remaining_next = remaining_reg;
        new_res        = 1'b0;
        new_item.payload_byte = s_axis_tdata;
        new_item.frame_type   = type_reg;
        new_item.last         = (remaining_reg == LEN_W'(1));
        new_item.empty_res    = 1'b0;

        if (in_payload)
        begin
            new_res        = 1'b1;
            remaining_next = remaining_reg - LEN_W'(1);
        end
        else
        begin
            if (pos_reg == '0)
            begin
                type_next = TYPE_W'(s_axis_tdata);
                len_next  = '0;
            end
            else if (pos_reg < POS_LEN0)
            begin
                type_next = {type_reg[TYPE_W-BYTE_W-1:0], s_axis_tdata};
            end
            else
            begin
                len_next = len_shift;
            end

            if (pos_reg == POS_LAST)
            begin
                pos_next = '0;
                // The final header byte is always a length byte, so len_shift
                // already holds the whole length here.
                if (len_shift == '0)
                begin
                    new_res = 1'b1;
                    new_item.payload_byte = '0;
                    new_item.frame_type   = type_next;
                    new_item.last         = 1'b1;
                    new_item.empty_res    = 1'b1;
                end
                else
                begin
                    remaining_next = len_shift;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            remaining_reg <= remaining_next;
        end
    end

    // Result buffer: a new result goes to the output register when that is
    // free or being taken, otherwise it waits in the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && new_res)
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (drain)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && new_res)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_reg <= new_item;
            end
            else
            begin
                skid_reg <= new_item;
            end
        end
        else if (drain && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign s_axis_tready   = !skid_valid_reg;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_reg.frame_type, out_reg.payload_byte};
    assign m_axis_tlast    = out_reg.last;
    assign m_axis_tuser[0] = out_reg.empty_res;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_pos_idle_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload |-> (pos_reg == '0))
        else $error("header position moved during the payload");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("header position beyond the header");

    a_header_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_payload && (pos_reg != POS_LAST)) |=> !in_payload)
        else $error("payload phase entered before the header was complete");

    a_final_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (remaining_reg == LEN_W'(1)) && !out_valid_reg)
        |=> (m_axis_tvalid && m_axis_tlast && !in_payload))
        else $error("final payload byte not marked last");

endmodule

FILE: verif/tlv_frame_parser_test.sv
// Self-checking testbench for tlv_frame_parser: drives framed byte streams with
// random gaps and receiver stalls and checks every result against a predictor.
// Depends on tlvfp_pkg and the tlv_frame_parser RTL.
module tlv_frame_parser_test;
    import tlvfp_pkg::*;

    localparam int HEADER_BYTES = TYPE_BYTES_DEF + LENGTH_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;

    // Tracks the parse state of the byte stream and holds the results that
    // the block still owes, oldest first.
    class frame_scoreboard;
        result_t           pending_results[$];
        int                mismatches;
        logic [2:0]        hdr_pos;
        logic [TYPE_W-1:0] cur_type;
        logic [31:0]       len_acc;
        logic [31:0]       payload_left;

        function new();
            mismatches   = 0;
            hdr_pos      = '0;
            cur_type     = '0;
            len_acc      = '0;
            payload_left = '0;
        endfunction

        function void accept_byte(logic [BYTE_W-1:0] b);
            result_t r;
            if (payload_left != 0) begin
                r.payload_byte = b;
                r.frame_type   = cur_type;
                r.last         = (payload_left == 1);
                r.empty_res    = 1'b0;
                payload_left   = payload_left - 1;
                pending_results.push_back(r);
            end
            else begin
                if (hdr_pos == 0) begin
                    cur_type = TYPE_W'(b);
                    len_acc  = '0;
                end
                else if (int'(hdr_pos) < TYPE_BYTES_DEF)
                    cur_type = {cur_type[TYPE_W-BYTE_W-1:0], b};
                else
                    len_acc = {len_acc[23:0], b};

                if (int'(hdr_pos) + 1 >= HEADER_BYTES) begin
                    hdr_pos = '0;
                    // A zero-length frame still owes one result, flagged empty.
                    if (len_acc == 0) begin
                        r.payload_byte = '0;
                        r.frame_type   = cur_type;
                        r.last         = 1'b1;
                        r.empty_res    = 1'b1;
                        pending_results.push_back(r);
                    end
                    else
                        payload_left = len_acc;
                end
                else
                    hdr_pos = hdr_pos + 3'd1;
            end
        endfunction

        function void report_field(string name, logic [TYPE_W-1:0] exp_val,
                                   logic [TYPE_W-1:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatches++;
            end
            else begin
                want = pending_results.pop_front();
                report_field("payload_byte", TYPE_W'(want.payload_byte),
                             TYPE_W'(got.payload_byte));
                report_field("frame_type", want.frame_type, got.frame_type);
                report_field("last", TYPE_W'(want.last), TYPE_W'(got.last));
                report_field("empty_res", TYPE_W'(want.empty_res), TYPE_W'(got.empty_res));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;    // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // [7:0] payload_byte, [23:8] frame_type
    logic                  m_axis_tlast;    // last
    logic [0:0]            m_axis_tuser;    // [0] empty_res

    frame_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              bytes_sent;
    int              cycle_count;
    int              hold_left;
    bit              hold_request;
    bit              hold_done;

    tlv_frame_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent    = 0;
        cycle_count   = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    always @(negedge clk)
    begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(result_t'({m_axis_tuser[0], m_axis_tlast, m_axis_tdata}));
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [TYPE_W-1:0] ftype, input logic [31:0] len);
        for (int i = TYPE_BYTES_DEF - 1; i >= 0; i--)
            send_byte(BYTE_W'(ftype >> (8 * i)));
        for (int i = LENGTH_BYTES_DEF - 1; i >= 0; i--)
            send_byte(BYTE_W'(len >> (8 * i)));
    endtask

    task automatic send_random_frames(input int target);
        logic [TYPE_W-1:0] ftype;
        int                len;
        int                pick;
        while (bytes_sent < target) begin
            ftype = TYPE_W'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 15)
                len = 0;
            else if (pick < 95)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(13, 300);
            send_header(ftype, len);
            for (int i = 0; i < len; i++)
                send_byte(BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 65;

        // Directed frames: extreme type and payload values, a zero type, and an
        // empty frame sitting between two full ones.
        send_header(16'hFFFF, 32'd1);
        send_byte(8'hFF);
        send_header(16'h0000, 32'd0);
        send_header(16'h0000, 32'd2);
        send_byte(8'h00);
        send_byte(8'hA5);

        send_random_frames(670);

        send_idle_pct = 65;
        recv_idle_pct = 23;
        send_random_frames(1300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_random_frames(1950);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
